@@ hw/rtl/i2c_trf_pkg.sv @@
// Package for the I2C target register file: table geometry, bus event codes,
// payload structs and the table reset contents. No dependencies.
`default_nettype none

package i2c_trf_pkg;

   localparam int TABLE_SIZE   = 20;
   localparam int STATUS_INDEX = 0;
   localparam int IDX_W        = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int PTR_W        = 8;
   localparam int BYTE_W       = 8;
   localparam int CMD_W        = 3;
   localparam int CSR_IDX_W    = 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADDR  = 3'd0,
      CMD_RX    = 3'd1,
      CMD_TX    = 3'd2,
      CMD_STOP  = 3'd3,
      CMD_ERROR = 3'd4
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIN_START = 1'b0,
      CSR_WIN_END   = 1'b1
   } csr_index_type;

   localparam logic [BYTE_W-1:0] WIN_START_RESET = 8'd0;
   localparam logic [BYTE_W-1:0] WIN_END_RESET   = 8'd19;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic              dir_write;
      logic [BYTE_W-1:0] rx_byte;
      logic [BYTE_W-1:0] error_bits;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] tx_byte;
      logic              tx_valid;
   } rsp_type;

   // power-on contents of the register table
   function automatic logic [BYTE_W-1:0] table_reset(input int idx);
      logic [BYTE_W-1:0] v;
      v = '0;
      case (idx)
         1:       v = 8'h80;
         17:      v = 8'h01;
         19:      v = 8'h09;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/i2c_trf_if.sv @@
// Valid/ready channel interfaces for the I2C target register file.
// Depends on i2c_trf_pkg for field widths.
`default_nettype none

interface i2c_trf_req_if;
   logic                              valid;
   logic                              ready;
   logic [i2c_trf_pkg::CMD_W-1:0]     cmd;
   logic                              dir_write;
   logic [i2c_trf_pkg::BYTE_W-1:0]    rx_byte;
   logic [i2c_trf_pkg::BYTE_W-1:0]    error_bits;

   modport source (output valid, output cmd, output dir_write, output rx_byte,
                   output error_bits, input ready);
   modport sink   (input valid, input cmd, input dir_write, input rx_byte,
                   input error_bits, output ready);
endinterface

interface i2c_trf_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [i2c_trf_pkg::BYTE_W-1:0]    tx_byte;
   logic                              tx_valid;

   modport source (output valid, output tx_byte, output tx_valid, input ready);
   modport sink   (input valid, input tx_byte, input tx_valid, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/i2c_target_register_file_core.sv @@
// Top level of the I2C target register file: input register, event decode,
// register table and result register. Depends on i2c_trf_pkg and i2c_trf_if.
//
//   channel  | direction | handshake    | payload
//   req_if   | in        | valid/ready  | cmd, dir_write, rx_byte, error_bits
//   rsp_if   | out       | valid/ready  | tx_byte, tx_valid
//   csr_*    | in        | write enable | window start/end, 8 bits
//
// One transaction per cycle sustained while rsp_if is ready; an accepted req is held in the
// input register and then moves into the result register, which drives rsp_if.valid.
// The table access and pointer update happen as an item moves from the input
// register into the result register, so each event sees all earlier updates.
// A stalled rsp holds the result register; one more item waits in the input
// register before req_if.ready drops.
// Synchronous reset loads the table preset bytes and clears pointer and flags.
`default_nettype none

module i2c_target_register_file_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   i2c_trf_req_if.sink                              req_if,
   i2c_trf_rsp_if.source                            rsp_if,
   input  wire logic                                csr_we,
   input  wire logic [i2c_trf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [i2c_trf_pkg::BYTE_W-1:0]      csr_wdata
);

   localparam int TS = i2c_trf_pkg::TABLE_SIZE;
   localparam int IW = i2c_trf_pkg::IDX_W;
   localparam int PW = i2c_trf_pkg::PTR_W;
   localparam int BW = i2c_trf_pkg::BYTE_W;
   localparam logic [PW:0] TABLE_END = (PW+1)'(TS);
   localparam logic        STATUS_IN_TABLE = (i2c_trf_pkg::STATUS_INDEX < TS);
   localparam logic [IW-1:0] STATUS_IDX = IW'(i2c_trf_pkg::STATUS_INDEX);

   // pipeline registers
   logic                  in_valid_ff;
   i2c_trf_pkg::req_type  in_ff;
   logic                  out_valid_ff;
   i2c_trf_pkg::rsp_type  out_ff;

   // architectural state
   logic [BW-1:0]         tbl_ff [TS];
   logic [PW-1:0]         ptr_ff, ptr_in;
   logic                  expect_ptr_ff, expect_ptr_in;
   logic [BW-1:0]         win_start_ff, win_end_ff;

   logic                  out_load;
   logic                  advance;
   logic                  ptr_in_table;
   logic [BW-1:0]         rd_byte;
   logic [PW:0]           ptr_inc_wide;
   logic                  wr_en;
   logic [IW-1:0]         wr_idx;
   logic [BW-1:0]         wr_data;
   i2c_trf_pkg::rsp_type  rsp_in;

   assign out_load      = !out_valid_ff || rsp_if.ready;
   assign advance       = in_valid_ff && out_load;
   assign req_if.ready  = !in_valid_ff || out_load;

   assign ptr_in_table  = ({1'b0, ptr_ff} < TABLE_END);
   assign rd_byte       = ptr_in_table ? tbl_ff[ptr_ff[IW-1:0]] : '0;
   assign ptr_inc_wide  = {1'b0, ptr_ff} + (PW+1)'(1);

   // event decode
   always_comb begin
      ptr_in        = ptr_ff;
      expect_ptr_in = expect_ptr_ff;
      wr_en         = 1'b0;
      wr_idx        = ptr_ff[IW-1:0];
      wr_data       = in_ff.rx_byte;
      rsp_in        = '0;
      case (in_ff.cmd)
         i2c_trf_pkg::CMD_ADDR: begin
            if (in_ff.dir_write) begin
               expect_ptr_in = 1'b1;
            end
         end
         i2c_trf_pkg::CMD_RX: begin
            if (expect_ptr_ff) begin
               ptr_in        = in_ff.rx_byte;
               expect_ptr_in = 1'b0;
            end else if (ptr_ff < win_start_ff || ptr_ff > win_end_ff) begin
               ptr_in = '0;
            end else begin
               wr_en  = ptr_in_table;
               ptr_in = ptr_inc_wide[PW-1:0];
            end
         end
         i2c_trf_pkg::CMD_TX: begin
            rsp_in.tx_valid = 1'b1;
            rsp_in.tx_byte  = rd_byte;
            ptr_in = (ptr_inc_wide >= TABLE_END) ? '0 : ptr_inc_wide[PW-1:0];
         end
         i2c_trf_pkg::CMD_STOP: begin
            ptr_in = '0;
         end
         i2c_trf_pkg::CMD_ERROR: begin
            ptr_in  = '0;
            wr_en   = STATUS_IN_TABLE;
            wr_idx  = STATUS_IDX;
            wr_data = tbl_ff[STATUS_IDX] | in_ff.error_bits;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
      if (req_if.ready) begin
         in_ff.cmd        <= req_if.cmd;
         in_ff.dir_write  <= req_if.dir_write;
         in_ff.rx_byte    <= req_if.rx_byte;
         in_ff.error_bits <= req_if.error_bits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= in_valid_ff;
      end
      if (advance) begin
         out_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff        <= '0;
         expect_ptr_ff <= 1'b0;
      end else if (advance) begin
         ptr_ff        <= ptr_in;
         expect_ptr_ff <= expect_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TS; i++) begin
            tbl_ff[i] <= i2c_trf_pkg::table_reset(i);
         end
      end else if (advance && wr_en) begin
         tbl_ff[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_start_ff <= i2c_trf_pkg::WIN_START_RESET;
         win_end_ff   <= i2c_trf_pkg::WIN_END_RESET;
      end else if (csr_we) begin
         case (csr_index)
            i2c_trf_pkg::CSR_WIN_START: win_start_ff <= csr_wdata;
            i2c_trf_pkg::CSR_WIN_END:   win_end_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_if.valid    = out_valid_ff;
   assign rsp_if.tx_byte  = out_ff.tx_byte;
   assign rsp_if.tx_valid = out_ff.tx_valid;

   // a non-transmit result always carries a zero byte
   a_zero_when_no_tx: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.tx_valid |-> out_ff.tx_byte == '0)
      else $error("tx_byte nonzero without tx_valid");

   // a transmit request leaves the pointer inside the table
   a_tx_wraps: assert property (@(posedge clock) disable iff (reset)
      advance && in_ff.cmd == i2c_trf_pkg::CMD_TX |=> ptr_in_table)
      else $error("pointer outside table after transmit");

   // stop and error clear the pointer
   a_clear_ptr: assert property (@(posedge clock) disable iff (reset)
      advance && (in_ff.cmd == i2c_trf_pkg::CMD_STOP
                  || in_ff.cmd == i2c_trf_pkg::CMD_ERROR) |=> ptr_ff == '0)
      else $error("pointer not cleared on stop or error");

   // result drains when taken and nothing is queued behind it
   a_drain: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_if.ready && !in_valid_ff |=> !out_valid_ff)
      else $error("stale result after drain");

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Testbench for i2c_target_register_file_core: drives bus event transactions
// with random idling, predicts each response and compares field by field.
// Depends on i2c_trf_pkg, i2c_trf_req_if and i2c_trf_rsp_if from the RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import i2c_trf_pkg::*;

   localparam int STALL_LIMIT = 2000;

   // Shadow copy of the register bank; predicts one response per bus event.
   class regbank_checker;
      logic [BYTE_W-1:0] regs [TABLE_SIZE];
      logic [PTR_W-1:0]  ptr;
      bit                ptr_armed;
      logic [BYTE_W-1:0] win_lo;
      logic [BYTE_W-1:0] win_hi;
      rsp_type           replies_due [$];
      int                failures;

      function new();
         foreach (regs[i]) regs[i] = '0;
         if (TABLE_SIZE > 1) regs[1] = 8'h80;
         if (TABLE_SIZE > 17) regs[17] = 8'h01;
         if (TABLE_SIZE > 19) regs[19] = 8'h09;
         ptr       = '0;
         ptr_armed = 1'b0;
         win_lo    = WIN_START_RESET;
         win_hi    = WIN_END_RESET;
         failures  = 0;
      endfunction

      function rsp_type apply_event(req_type e);
         rsp_type o;
         int      p;
         o = '0;
         p = ptr;
         case (e.cmd)
            CMD_ADDR: begin
               if (e.dir_write) ptr_armed = 1'b1;
            end
            CMD_RX: begin
               if (ptr_armed) begin
                  ptr       = e.rx_byte;
                  ptr_armed = 1'b0;
               end else if (p < win_lo || p > win_hi) begin
                  ptr = '0;
               end else begin
                  // in window but past the table: byte dropped, pointer still moves
                  if (p < TABLE_SIZE) regs[p] = e.rx_byte;
                  ptr = PTR_W'(p + 1);
               end
            end
            CMD_TX: begin
               o.tx_valid = 1'b1;
               if (p < TABLE_SIZE) o.tx_byte = regs[p];
               p = p + 1;
               if (p >= TABLE_SIZE) p = 0;
               ptr = PTR_W'(p);
            end
            CMD_STOP: begin
               ptr = '0;
            end
            CMD_ERROR: begin
               ptr = '0;
               if (STATUS_INDEX < TABLE_SIZE)
                  regs[STATUS_INDEX] = regs[STATUS_INDEX] | e.error_bits;
            end
            default: ;
         endcase
         return o;
      endfunction

      function void note_event(req_type e);
         replies_due.push_back(apply_event(e));
      endfunction

      function void check_reply(rsp_type got);
         rsp_type want;
         if (replies_due.size() == 0) begin
            $error("unexpected response: tx_byte %02h tx_valid %0b",
                   got.tx_byte, got.tx_valid);
            failures++;
            return;
         end
         want = replies_due.pop_front();
         if (got.tx_byte !== want.tx_byte) begin
            $error("tx_byte: expected %02h, got %02h", want.tx_byte, got.tx_byte);
            failures++;
         end
         if (got.tx_valid !== want.tx_valid) begin
            $error("tx_valid: expected %0b, got %0b", want.tx_valid, got.tx_valid);
            failures++;
         end
      endfunction

      function int pending();
         return replies_due.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BYTE_W-1:0]    csr_wdata;

   i2c_trf_req_if req_ch ();
   i2c_trf_rsp_if rsp_ch ();

   i2c_target_register_file_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   regbank_checker board = new();

   int send_idle_pct;
   int recv_idle_pct;
   int events_sent;
   int stall_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // transaction monitor and watchdog
   always @(posedge clock) begin : watch_channels
      req_type seen_req;
      rsp_type seen_rsp;
      bit      moved;
      moved = 1'b0;
      if (!reset && req_ch.valid && req_ch.ready) begin
         seen_req.cmd        = req_ch.cmd;
         seen_req.dir_write  = req_ch.dir_write;
         seen_req.rx_byte    = req_ch.rx_byte;
         seen_req.error_bits = req_ch.error_bits;
         board.note_event(seen_req);
         moved = 1'b1;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         seen_rsp.tx_byte  = rsp_ch.tx_byte;
         seen_rsp.tx_valid = rsp_ch.tx_valid;
         board.check_reply(seen_rsp);
         moved = 1'b1;
      end
      if (moved) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // val goes to the field the command uses; the other fields are random
   task automatic bus_event(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] val);
      req_type e;
      e.cmd        = c;
      e.dir_write  = 1'($urandom_range(0, 1));
      e.rx_byte    = BYTE_W'($urandom_range(0, 255));
      e.error_bits = BYTE_W'($urandom_range(0, 255));
      case (c)
         CMD_ADDR:  e.dir_write  = val[0];
         CMD_RX:    e.rx_byte    = val;
         CMD_ERROR: e.error_bits = val;
         default: ;
      endcase
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.cmd        <= e.cmd;
      req_ch.dir_write  <= e.dir_write;
      req_ch.rx_byte    <= e.rx_byte;
      req_ch.error_bits <= e.error_bits;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (c <= CMD_ERROR) events_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_window(input logic [BYTE_W-1:0] lo, input logic [BYTE_W-1:0] hi);
      csr_we    <= 1'b1;
      csr_index <= CSR_WIN_START;
      csr_wdata <= lo;
      @(negedge clock);
      csr_index <= CSR_WIN_END;
      csr_wdata <= hi;
      @(negedge clock);
      csr_we <= 1'b0;
      board.win_lo = lo;
      board.win_hi = hi;
   endtask

   function automatic logic [BYTE_W-1:0] pick_pointer();
      if ($urandom_range(0, 99) < 85) return BYTE_W'($urandom_range(0, TABLE_SIZE + 2));
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   // mostly well-formed host transactions, some errors and stray events
   task automatic random_transaction();
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
         bus_event(CMD_ADDR, 8'd1);
         bus_event(CMD_RX, pick_pointer());
         repeat ($urandom_range(0, 6)) bus_event(CMD_RX, BYTE_W'($urandom_range(0, 255)));
         if ($urandom_range(0, 9) != 0) bus_event(CMD_STOP, 8'd0);
      end else if (kind < 80) begin
         if ($urandom_range(0, 1) != 0) begin
            bus_event(CMD_ADDR, 8'd1);
            bus_event(CMD_RX, pick_pointer());
         end
         bus_event(CMD_ADDR, 8'd0);
         repeat ($urandom_range(1, 6)) bus_event(CMD_TX, 8'd0);
         if ($urandom_range(0, 9) != 0) bus_event(CMD_STOP, 8'd0);
      end else if (kind < 88) begin
         bus_event(CMD_ERROR, ($urandom_range(0, 3) == 0) ? BYTE_W'($urandom_range(0, 255))
                                                         : BYTE_W'(1 << $urandom_range(0, 7)));
      end else begin
         bus_event(CMD_W'($urandom_range(0, 7)), BYTE_W'($urandom_range(0, 255)));
      end
   endtask

   initial begin : stimulus
      int               goal;
      logic [BYTE_W-1:0] lo;
      logic [BYTE_W-1:0] hi;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.cmd        = '0;
      req_ch.dir_write  = 1'b0;
      req_ch.rx_byte    = '0;
      req_ch.error_bits = '0;
      rsp_ch.ready      = 1'b0;
      csr_we            = 1'b0;
      csr_index         = CSR_WIN_START;
      csr_wdata         = '0;
      send_idle_pct     = 22;
      recv_idle_pct     = 62;
      events_sent       = 0;
      stall_cycles      = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, reset window
      bus_event(CMD_ADDR, 8'd0);          // read match leaves state alone
      bus_event(CMD_TX, 8'd0);
      bus_event(CMD_TX, 8'd0);
      bus_event(CMD_ADDR, 8'd1);
      bus_event(CMD_RX, 8'hFF);           // pointer loaded past the table
      bus_event(CMD_TX, 8'd0);            // reads zero, pointer wraps
      bus_event(CMD_ADDR, 8'd1);
      bus_event(CMD_STOP, 8'd0);          // pointer-byte flag survives stop
      bus_event(CMD_RX, 8'h12);
      bus_event(CMD_RX, 8'hAA);
      bus_event(CMD_RX, 8'h00);
      bus_event(CMD_RX, 8'h5A);           // pointer left window
      bus_event(CMD_ERROR, 8'hFF);
      bus_event(CMD_ERROR, 8'h00);
      bus_event(CMD_TX, 8'd0);
      bus_event(CMD_W'(5), 8'd0);
      bus_event(CMD_W'(6), 8'd0);
      bus_event(CMD_W'(7), 8'd0);

      // full window: writes past the table, pointer wraps at 256
      wait_idle();
      set_window(8'd0, 8'd255);
      bus_event(CMD_ADDR, 8'd1);
      bus_event(CMD_RX, 8'hFE);
      bus_event(CMD_RX, 8'h11);
      bus_event(CMD_RX, 8'h22);

      // empty window
      wait_idle();
      set_window(8'd200, 8'd100);
      bus_event(CMD_ADDR, 8'd1);
      bus_event(CMD_RX, 8'h05);
      bus_event(CMD_RX, 8'h77);

      for (int phase = 0; phase < 6; phase++) begin
         wait_idle();
         case (phase / 2)
            0: begin send_idle_pct = 22; recv_idle_pct = 62; end
            1: begin send_idle_pct = 62; recv_idle_pct = 22; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         lo = BYTE_W'($urandom_range(0, TABLE_SIZE - 1));
         hi = BYTE_W'($urandom_range(lo, TABLE_SIZE + 2));
         case (phase)
            0: set_window(8'd0, 8'd255);
            2: set_window(8'd0, 8'd0);
            3: set_window(8'd255, 8'd255);
            5: set_window(WIN_START_RESET, WIN_END_RESET);
            default: set_window(lo, hi);
         endcase
         goal = events_sent + 175;
         while (events_sent < goal) random_transaction();
      end

      wait_idle();
      if (board.failures == 0 && board.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
